// ----- rtl/thdt_pkg.sv -----
package thdt_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_PAD_COUNT = 4;
  localparam int DEF_TIME_BITS = 16;

  // Fixed field widths.
  localparam int PAD_IDX_W   = 2;
  localparam int TICK_W      = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;
  localparam int RESULT_W    = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ENABLE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HOLD_TIME  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DOUBLE_TIME = 2'd2;

  localparam logic              RST_GESTURES_ENABLE = 1'b0;
  localparam logic [TICK_W-1:0] RST_HOLD_TIME       = 16'd500;
  localparam logic [TICK_W-1:0] RST_DOUBLE_TAP_TIME = 16'd250;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_HOLD     = 3'd3,
    PH_DOUBLE   = 3'd4,
    PH_CONSUMED = 3'd5
  } phase_e;

  // Input frame, last field in the lowest bits.
  typedef struct packed {
    logic                 double_in;
    logic                 hold_in;
    logic                 tap_in;
    logic [TICK_W-1:0]    elapsed_ticks;
    logic                 went_down;
    logic                 held;
    logic                 pad_active;
    logic [PAD_IDX_W-1:0] pad_index;
  } item_t;

  typedef struct packed {
    logic double_out;
    logic hold_out;
    logic tap_out;
  } result_t;

  typedef struct packed {
    logic              gestures_enable;
    logic [TICK_W-1:0] hold_time;
    logic [TICK_W-1:0] double_tap_time;
  } cfg_t;

endpackage

// ----- rtl/tap_hold_double_tap_classifier_core.sv -----
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid_i/tready_o     tdata[23:0] input frame
// m_axis    out        m_axis_tvalid_o/tready_i     tdata[7:0] gesture flags
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_addr_i, cfg_data_i
//
// One frame per cycle sustained while results are taken; a frame passes the input register, then the result register.
// A frame waits in the input register and is classified combinationally against
// the per-pad state, which is written back at the same edge the result register loads,
// so back-to-back frames for the same pad see the updated state.
// Reset clears every pad to idle with a zero timer and loads the register defaults.
// A stalled output holds the result and the input register takes one more frame.
module tap_hold_double_tap_classifier_core #(
  parameter int PAD_COUNT = thdt_pkg::DEF_PAD_COUNT,
  parameter int TIME_BITS = thdt_pkg::DEF_TIME_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // pad_index[1:0], pad_active, held, went_down, elapsed_ticks[15:0],
  // tap_in, hold_in, double_in
  input  logic [thdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tap_out, hold_out, double_out, then five zero bits
  output logic [thdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [thdt_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [thdt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import thdt_pkg::*;

  localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  cfg_t                 cfg_q;
  item_t                item_q;
  logic                 in_valid_q;
  result_t              res_q;
  logic                 out_valid_q;
  phase_e               phase_q [PAD_COUNT];
  logic [TIME_BITS-1:0] timer_q [PAD_COUNT];

  logic                 advance;
  logic                 process;
  logic                 in_range;
  logic [PAD_W-1:0]     pad_idx;
  phase_e               phase_cur;
  logic [TIME_BITS-1:0] timer_cur;
  phase_e               phase_d;
  logic [TIME_BITS-1:0] timer_d;
  result_t              res_step;
  result_t              res_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gestures_enable <= RST_GESTURES_ENABLE;
      cfg_q.hold_time       <= RST_HOLD_TIME;
      cfg_q.double_tap_time <= RST_DOUBLE_TAP_TIME;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_IDX_ENABLE:      cfg_q.gestures_enable <= cfg_data_i[0];
        CFG_IDX_HOLD_TIME:   cfg_q.hold_time       <= cfg_data_i;
        CFG_IDX_DOUBLE_TIME: cfg_q.double_tap_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The input register drains whenever the result register is free or being taken.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign process         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= item_t'(s_axis_tdata_i);
    end
  end

  assign in_range  = 32'(item_q.pad_index) < PAD_COUNT;
  assign pad_idx   = PAD_W'(item_q.pad_index);
  assign phase_cur = phase_q[pad_idx];
  assign timer_cur = timer_q[pad_idx];

  thdt_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .phase_i(phase_cur),
    .timer_i(timer_cur),
    .phase_o(phase_d),
    .timer_o(timer_d),
    .res_o  (res_step)
  );

  assign res_d = in_range ? res_step : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PAD_COUNT; p++) begin
        phase_q[p] <= PH_IDLE;
        timer_q[p] <= '0;
      end
    end else if (process && in_range) begin
      phase_q[pad_idx] <= phase_d;
      timer_q[pad_idx] <= timer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_q.double_out,
                            res_q.hold_out, res_q.tap_out};

  // With gestures on, a tap never shares a frame with hold or double.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.tap_out && (res_q.hold_out || res_q.double_out))
      |-> !cfg_q.gestures_enable)
    else $error("tap reported together with hold or double while classifying");

  // An empty result register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");

  // A frame for an inactive pad leaves that pad idle with a cleared timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && in_range && !item_q.pad_active)
      |=> (phase_q[$past(pad_idx)] == PH_IDLE) && (timer_q[$past(pad_idx)] == '0))
    else $error("inactive pad state not cleared");

endmodule

// ----- rtl/thdt_step.sv -----
module thdt_step #(
  parameter int TIME_BITS = thdt_pkg::DEF_TIME_BITS
) (
  input  thdt_pkg::item_t   item_i,
  input  thdt_pkg::cfg_t    cfg_i,
  input  thdt_pkg::phase_e  phase_i,
  input  logic [TIME_BITS-1:0] timer_i,
  output thdt_pkg::phase_e  phase_o,
  output logic [TIME_BITS-1:0] timer_o,
  output thdt_pkg::result_t res_o
);
  import thdt_pkg::*;

  localparam int CMP_W = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;
  localparam int SUM_W = CMP_W + 1;

  logic [SUM_W-1:0]     sum;
  logic [TIME_BITS-1:0] t_sat;
  logic [CMP_W-1:0]     t_cmp;
  logic [CMP_W-1:0]     hold_cmp;
  logic [CMP_W-1:0]     dbl_cmp;

  // Saturating timer advance.
  always_comb begin
    sum = SUM_W'(timer_i) + SUM_W'(item_i.elapsed_ticks);
    if (sum > SUM_W'({TIME_BITS{1'b1}})) begin
      t_sat = {TIME_BITS{1'b1}};
    end else begin
      t_sat = sum[TIME_BITS-1:0];
    end
    t_cmp    = CMP_W'(t_sat);
    hold_cmp = CMP_W'(cfg_i.hold_time);
    dbl_cmp  = CMP_W'(cfg_i.double_tap_time);
  end

  always_comb begin
    phase_o = phase_i;
    timer_o = timer_i;
    res_o   = '0;
    if (!item_i.pad_active) begin
      phase_o = PH_IDLE;
      timer_o = '0;
    end else if (!cfg_i.gestures_enable) begin
      phase_o           = PH_IDLE;
      timer_o           = '0;
      res_o.tap_out     = item_i.tap_in;
      res_o.hold_out    = item_i.hold_in;
      res_o.double_out  = item_i.double_in;
    end else if (item_i.hold_in || item_i.double_in) begin
      // An upstream action takes the gesture; the timer stays where it is.
      phase_o          = PH_CONSUMED;
      res_o.hold_out   = item_i.hold_in;
      res_o.double_out = item_i.double_in;
    end else begin
      timer_o = t_sat;
      unique case (phase_i)
        PH_PRESSED: begin
          if (!item_i.held) begin
            phase_o = PH_RELEASED;
            timer_o = '0;
          end else if (t_cmp >= hold_cmp) begin
            phase_o        = PH_HOLD;
            res_o.hold_out = 1'b1;
          end
        end
        PH_RELEASED: begin
          if (item_i.went_down && (t_cmp <= dbl_cmp)) begin
            phase_o          = PH_DOUBLE;
            res_o.double_out = 1'b1;
          end else if (t_cmp >= dbl_cmp) begin
            res_o.tap_out = 1'b1;
            phase_o       = item_i.went_down ? PH_PRESSED : PH_IDLE;
            timer_o       = '0;
          end
        end
        PH_HOLD: begin
          res_o.hold_out = item_i.held;
          if (!item_i.held) phase_o = PH_IDLE;
        end
        PH_DOUBLE: begin
          res_o.double_out = item_i.held;
          if (!item_i.held) phase_o = PH_IDLE;
        end
        PH_CONSUMED: begin
          if (!item_i.held) phase_o = PH_IDLE;
        end
        default: begin
          phase_o = PH_IDLE;
          if (item_i.went_down) begin
            phase_o = PH_PRESSED;
            timer_o = '0;
          end
        end
      endcase
    end
  end

endmodule

// ----- tb/thdt_gesture_checker.sv -----
`timescale 1ns / 1ps

module thdt_gesture_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [thdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [thdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [thdt_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [thdt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                               mismatch_count_o,
  output int                               pending_o
);
  import thdt_pkg::*;

  localparam int PADS = DEF_PAD_COUNT;

  logic              enable_q;
  logic [TICK_W-1:0] hold_time_q;
  logic [TICK_W-1:0] double_time_q;
  phase_e            phase_q [PADS];
  logic [TICK_W-1:0] timer_q [PADS];

  result_t expected_flags_q [$];
  result_t want_flags;
  result_t got_flags;
  int      mismatch_cnt = 0;
  int      pending_cnt = 0;

  assign mismatch_count_o = mismatch_cnt;
  assign pending_o        = pending_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] gesture result error: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    end
  endtask

  // Advances one pad's gesture state by one frame and returns the flags it gives.
  function automatic result_t classify_frame(input item_t f);
    result_t           r;
    logic [TICK_W:0]   sum;
    logic [TICK_W-1:0] t;
    int                p;
    r = '0;
    p = int'(f.pad_index);
    if (p >= PADS) begin
      return r;
    end
    if (!f.pad_active) begin
      phase_q[p] = PH_IDLE;
      timer_q[p] = '0;
    end else if (!enable_q) begin
      phase_q[p]   = PH_IDLE;
      timer_q[p]   = '0;
      r.tap_out    = f.tap_in;
      r.hold_out   = f.hold_in;
      r.double_out = f.double_in;
    end else if (f.hold_in || f.double_in) begin
      // An incoming action takes the gesture over; the timer stands still.
      phase_q[p]   = PH_CONSUMED;
      r.hold_out   = f.hold_in;
      r.double_out = f.double_in;
    end else begin
      sum = timer_q[p] + f.elapsed_ticks;
      t   = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
      case (phase_q[p])
        PH_PRESSED: begin
          if (!f.held) begin
            phase_q[p] = PH_RELEASED;
            t = '0;
          end else if (t >= hold_time_q) begin
            phase_q[p] = PH_HOLD;
            r.hold_out = 1'b1;
          end
        end
        PH_RELEASED: begin
          if (f.went_down && t <= double_time_q) begin
            phase_q[p]   = PH_DOUBLE;
            r.double_out = 1'b1;
          end else if (t >= double_time_q) begin
            r.tap_out  = 1'b1;
            phase_q[p] = f.went_down ? PH_PRESSED : PH_IDLE;
            t = '0;
          end
        end
        PH_HOLD: begin
          r.hold_out = f.held;
          if (!f.held) phase_q[p] = PH_IDLE;
        end
        PH_DOUBLE: begin
          r.double_out = f.held;
          if (!f.held) phase_q[p] = PH_IDLE;
        end
        PH_CONSUMED: begin
          if (!f.held) phase_q[p] = PH_IDLE;
        end
        default: begin
          phase_q[p] = f.went_down ? PH_PRESSED : PH_IDLE;
          if (f.went_down) t = '0;
        end
      endcase
      timer_q[p] = t;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      = RST_GESTURES_ENABLE;
      hold_time_q   = RST_HOLD_TIME;
      double_time_q = RST_DOUBLE_TAP_TIME;
      for (int p = 0; p < PADS; p++) begin
        phase_q[p] = PH_IDLE;
        timer_q[p] = '0;
      end
      expected_flags_q.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_IDX_ENABLE:      enable_q      = cfg_data_i[0];
          CFG_IDX_HOLD_TIME:   hold_time_q   = cfg_data_i;
          CFG_IDX_DOUBLE_TIME: double_time_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_flags_q.push_back(classify_frame(item_t'(s_axis_tdata_i)));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_flags_q.size() == 0) begin
          report_mismatch("result transaction with no frame outstanding");
        end else begin
          want_flags = expected_flags_q.pop_front();
          got_flags  = result_t'(m_axis_tdata_i[RESULT_W-1:0]);
          check_flag("tap_out", got_flags.tap_out, want_flags.tap_out);
          check_flag("hold_out", got_flags.hold_out, want_flags.hold_out);
          check_flag("double_out", got_flags.double_out, want_flags.double_out);
          if (m_axis_tdata_i[OUT_TDATA_W-1:RESULT_W] !== '0) begin
            report_mismatch($sformatf("padding bits are %b",
                                      m_axis_tdata_i[OUT_TDATA_W-1:RESULT_W]));
          end
        end
      end
      pending_cnt = expected_flags_q.size();
    end
  end

endmodule

// ----- tb/tb_tap_hold_double_tap_classifier_core.sv -----
`timescale 1ns / 1ps

module tb_tap_hold_double_tap_classifier_core;
  import thdt_pkg::*;

  localparam int PHASES = 8;
  localparam int FRAMES_PER_PHASE = 125;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int mismatch_count;
  int frames_pending;
  int idle_pct = 0;
  int stall_pct = 0;
  logic button_down [DEF_PAD_COUNT] = '{default: 1'b0};

  // Per phase: enable, hold time, double-tap window, typical tick step, idling, stalling.
  logic        enable_set [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
  int unsigned hold_set   [PHASES] = '{20, 20, 0, 65535, 100, 6, 300, 1};
  int unsigned window_set [PHASES] = '{12, 12, 0, 65535, 50, 3, 200, 65535};
  int unsigned span_set   [PHASES] = '{8, 8, 4, 30000, 40, 3, 120, 10};
  int          idle_set   [PHASES] = '{0, 63, 0, 17, 17, 63, 0, 0};
  int          stall_set  [PHASES] = '{0, 0, 63, 17, 17, 0, 63, 0};

  always #1 clk_i = ~clk_i;

  tap_hold_double_tap_classifier_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  thdt_gesture_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (frames_pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_frame(input item_t f);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= f;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic frame(input logic [PAD_IDX_W-1:0] pad, input logic act, input logic hld,
                       input logic wdn, input logic [TICK_W-1:0] ticks,
                       input logic tap, input logic hin, input logic din);
    item_t f;
    f.pad_index     = pad;
    f.pad_active    = act;
    f.held          = hld;
    f.went_down     = wdn;
    f.elapsed_ticks = ticks;
    f.tap_in        = tap;
    f.hold_in       = hin;
    f.double_in     = din;
    send_frame(f);
  endtask

  // Stops the sender and waits for every outstanding result.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; valid stays high between them.
  task automatic write_config(input logic en, input logic [TICK_W-1:0] hold_t,
                              input logic [TICK_W-1:0] window_t);
    logic [CFG_ADDR_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_IDX_ENABLE, CFG_IDX_HOLD_TIME, CFG_IDX_DOUBLE_TIME};
    val = '{{15'($urandom), en}, hold_t, window_t};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    item_t       f;
    int          roll;
    int          pick;
    int unsigned span;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Gestures are off after reset, so flags pass straight through.
    frame(2'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    frame(2'd3, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
    frame(2'd1, 1'b0, 1'b1, 1'b1, 16'h1234, 1'b1, 1'b1, 1'b1);
    wait_drained();
    write_config(1'b1, 16'd10, 16'd5);

    // Long hold, then the timer saturates while held.
    frame(2'd0, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    frame(2'd0, 1'b1, 1'b1, 1'b0, 16'd4, 1'b1, 1'b0, 1'b0);
    frame(2'd0, 1'b1, 1'b1, 1'b0, 16'd6, 1'b0, 1'b0, 1'b0);
    frame(2'd0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    frame(2'd0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    frame(2'd0, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0);
    // Second press exactly at the end of the window counts as a double.
    frame(2'd1, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    frame(2'd1, 1'b1, 1'b0, 1'b0, 16'd3, 1'b0, 1'b0, 1'b0);
    frame(2'd1, 1'b1, 1'b1, 1'b1, 16'd5, 1'b0, 1'b0, 1'b0);
    frame(2'd1, 1'b1, 1'b1, 1'b0, 16'd2, 1'b0, 1'b0, 1'b0);
    frame(2'd1, 1'b1, 1'b0, 1'b0, 16'd2, 1'b0, 1'b0, 1'b0);
    // Window expiring without a press is a tap; a late press is a tap plus a new press.
    frame(2'd2, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    frame(2'd2, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0);
    frame(2'd2, 1'b1, 1'b0, 1'b0, 16'd5, 1'b0, 1'b0, 1'b0);
    frame(2'd2, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    frame(2'd2, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0);
    frame(2'd2, 1'b1, 1'b1, 1'b1, 16'd9, 1'b0, 1'b0, 1'b0);
    // Incoming actions take the gesture over; an incoming tap is dropped.
    frame(2'd3, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
    frame(2'd3, 1'b1, 1'b1, 1'b0, 16'd2, 1'b0, 1'b1, 1'b0);
    frame(2'd3, 1'b1, 1'b1, 1'b0, 16'd20, 1'b1, 1'b0, 1'b0);
    frame(2'd3, 1'b1, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0, 1'b0);
    frame(2'd3, 1'b1, 1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_config(enable_set[ph], TICK_W'(hold_set[ph]), TICK_W'(window_set[ph]));
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      span      = span_set[ph];
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 88) begin
          // Plausible button activity on one pad, with random timing and flags.
          f.pad_index  = PAD_IDX_W'($urandom_range(0, DEF_PAD_COUNT - 1));
          f.pad_active = ($urandom_range(0, 49) != 0);
          if (button_down[f.pad_index]) begin
            f.held      = ($urandom_range(0, 9) < 7);
            f.went_down = 1'b0;
          end else begin
            f.held      = ($urandom_range(0, 9) < 4);
            f.went_down = f.held;
          end
          f.tap_in    = 1'($urandom_range(0, 1));
          f.hold_in   = ($urandom_range(0, 24) == 0);
          f.double_in = ($urandom_range(0, 24) == 0);
          pick = $urandom_range(0, 19);
          if (pick < 16) f.elapsed_ticks = TICK_W'($urandom_range(0, span));
          else if (pick < 18) f.elapsed_ticks = '0;
          else if (pick == 18) f.elapsed_ticks = '1;
          else f.elapsed_ticks = TICK_W'($urandom);
        end else begin
          f = item_t'(IN_TDATA_W'($urandom));
        end
        button_down[f.pad_index] = f.held;
        send_frame(f);
        if ($urandom_range(0, 63) == 0) wait_drained();
      end
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/thdt_pkg.sv
rtl/thdt_step.sv
rtl/tap_hold_double_tap_classifier_core.sv
tb/thdt_gesture_checker.sv
tb/tb_tap_hold_double_tap_classifier_core.sv
